// File: sv/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by modexp_mulmod and modular_exponentiation; no dependencies.
package modexp_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = 1'b1;

    typedef struct packed {
        logic start;
    } t_mul_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// File: sv/modexp_mulmod.sv
// Bit-serial modular multiplier: x * y mod m, one double or add step per cycle.
// Depends on modexp_pkg for the control and status structs.
module modexp_mulmod #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  modexp_pkg::t_mul_ctrl i_ctrl,
    input  logic [WIDTH-1:0]      i_x,
    input  logic [WIDTH-1:0]      i_y,
    input  logic [WIDTH-1:0]      i_m,
    output modexp_pkg::t_mul_stat o_stat,
    output logic [WIDTH-1:0]      o_result
);

    localparam int unsigned CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_x;
    logic [WIDTH-1:0] r_y;
    logic [WIDTH-1:0] r_m;
    logic [CW-1:0]    r_cnt;
    logic             r_phase;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0] w_dbl;
    logic [WIDTH:0] w_sum;
    logic [WIDTH:0] w_sel;
    logic [WIDTH:0] w_red;

    assign w_dbl = {r_r, 1'b0};
    assign w_sum = {1'b0, r_r} + {1'b0, r_x};
    assign w_sel = r_phase ? w_sum : w_dbl;
    assign w_red = (w_sel >= {1'b0, r_m}) ? (w_sel - {1'b0, r_m}) : w_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_x     <= i_x;
                r_y     <= i_y;
                r_m     <= i_m;
                r_r     <= '0;
                r_cnt   <= CW'(WIDTH - 1);
                r_phase <= 1'b0;
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                if (!r_phase) begin
                    r_r     <= w_red[WIDTH-1:0];
                    r_phase <= 1'b1;
                end else begin
                    if (r_y[WIDTH-1]) begin
                        r_r <= w_red[WIDTH-1:0];
                    end
                    r_y     <= {r_y[WIDTH-2:0], 1'b0};
                    r_phase <= 1'b0;
                    if (r_cnt == '0) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_r;

    a_partial_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_r < r_m))
        else $error("partial product not reduced");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> !r_busy)
        else $error("start while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && (r_r < r_m)))
        else $error("done with busy unit or unreduced result");

endmodule

// File: sv/modular_exponentiation.sv
// Modular exponentiation, left-to-right square-and-multiply over a shared serial multiplier.
// Each exponent bit takes one squaring, plus one multiply by the base when the bit is set;
// a zero modulus skips both steps and gives zero.
// Handshake: one beat at a time; the next beat is accepted in the cycle after the result is registered.
// Reset: synchronous active low; clears control, sets modulus to 1 and exponent to 0.
// Depends on modexp_pkg and modexp_mulmod.
module modular_exponentiation #(
    parameter int unsigned WIDTH    = 32,
    parameter int unsigned EXP_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [modexp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [modexp_pkg::DATA_W-1:0]     i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [modexp_pkg::DATA_W-1:0]     s_axis_tdata,  // [31:0] base
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [modexp_pkg::DATA_W-1:0]     m_axis_tdata   // [31:0] power
);

    localparam int unsigned KW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQR,
        ST_MUL,
        ST_HOLD
    } t_state;

    t_state                r_state;
    logic [WIDTH-1:0]      r_mod;
    logic [EXP_BITS-1:0]   r_exp;
    logic [WIDTH-1:0]      r_b;
    logic [EXP_BITS-1:0]   r_e;
    logic [KW-1:0]         r_k;
    logic [WIDTH-1:0]      r_acc;
    logic                  r_start;
    logic                  r_out_valid;
    logic [WIDTH-1:0]      r_out_data;

    modexp_pkg::t_mul_ctrl w_ctrl;
    modexp_pkg::t_mul_stat w_stat;
    logic [WIDTH-1:0]      w_y;
    logic [WIDTH-1:0]      w_prod;
    logic                  w_accept;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_ctrl.start  = r_start;
    assign w_y           = (r_state == ST_MUL) ? r_b : r_acc;

    modexp_mulmod #(
        .WIDTH(WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_x     (r_acc),
        .i_y     (w_y),
        .i_m     (r_mod),
        .o_stat  (w_stat),
        .o_result(w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= WIDTH'(1);
            r_exp <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == modexp_pkg::REG_MODULUS) begin
                r_mod <= i_cfg_wdata[WIDTH-1:0];
            end else if (i_cfg_addr == modexp_pkg::REG_EXPONENT) begin
                r_exp <= i_cfg_wdata[EXP_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            r_start <= 1'b0;
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_b <= s_axis_tdata[WIDTH-1:0];
                        r_e <= r_exp;
                        r_k <= KW'(EXP_BITS - 1);
                        if (r_mod == '0) begin
                            r_acc   <= '0;
                            r_state <= ST_HOLD;
                        end else begin
                            r_acc   <= (r_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
                            r_start <= 1'b1;
                            r_state <= ST_SQR;
                        end
                    end
                end
                ST_SQR: begin
                    if (w_stat.done) begin
                        r_acc <= w_prod;
                        if (r_e[EXP_BITS-1]) begin
                            r_start <= 1'b1;
                            r_state <= ST_MUL;
                        end else begin
                            r_e <= r_e << 1;
                            if (r_k == '0) begin
                                r_state <= ST_HOLD;
                            end else begin
                                r_k     <= r_k - 1'b1;
                                r_start <= 1'b1;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    if (w_stat.done) begin
                        r_acc <= w_prod;
                        r_e   <= r_e << 1;
                        if (r_k == '0) begin
                            r_state <= ST_HOLD;
                        end else begin
                            r_k     <= r_k - 1'b1;
                            r_start <= 1'b1;
                            r_state <= ST_SQR;
                        end
                    end
                end
                ST_HOLD: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = modexp_pkg::DATA_W'(r_out_data);

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) && (r_mod != '0)) |-> (r_acc < r_mod))
        else $error("accumulator not below modulus");

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (!w_stat.busy && ((r_state == ST_SQR) || (r_state == ST_MUL))))
        else $error("multiplier started while busy or outside a step");

    a_done_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> ((r_state == ST_SQR) || (r_state == ST_MUL)))
        else $error("multiplier done outside a step");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("ready right after accepting a beat");

endmodule
